// ===== hdl/ps2mt_pkg.sv =====
package ps2mt_pkg;

    // register map
    localparam int APB_AW = 3;
    localparam logic [APB_AW-1:0] ADDR_START_X = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_START_Y = 3'd4;

    localparam logic signed [31:0] START_X_RST = 32'sd400;
    localparam logic signed [31:0] START_Y_RST = 32'sd300;

    localparam int QUEUE_DEPTH_DEF = 4;

    // status bits
    localparam int STAT_OBF = 0;
    localparam int STAT_AUX = 5;

    // first-byte bits
    localparam int FB_LEFT   = 0;
    localparam int FB_RIGHT  = 1;
    localparam int FB_MIDDLE = 2;
    localparam int FB_SYNC   = 3;
    localparam int FB_XSIGN  = 4;
    localparam int FB_YSIGN  = 5;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        IDX_FIRST  = 2'd0,
        IDX_SECOND = 2'd1,
        IDX_THIRD  = 2'd2
    } t_idx;

    // one assembled packet
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } t_pkt;

    typedef struct packed {
        logic valid;
        t_pkt pkt;
    } t_push;

    // configuration write towards the position registers
    typedef struct packed {
        logic              wr_x;
        logic              wr_y;
        logic signed [31:0] data;
    } t_cfg;

endpackage

// ===== hdl/ps2mt_if.sv =====
interface ps2mt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ctrl_status;
    logic [7:0] rx_byte;

    modport source (output valid, output ctrl_status, output rx_byte, input ready);
    modport sink (input valid, input ctrl_status, input rx_byte, output ready);
endinterface

interface ps2mt_out_if;
    logic               valid;
    logic               ready;
    logic               button_left;
    logic               button_right;
    logic               button_middle;
    logic signed [8:0]  delta_x;
    logic signed [9:0]  delta_y;
    logic signed [31:0] cursor_x;
    logic signed [31:0] cursor_y;

    modport source (
        output valid, output button_left, output button_right, output button_middle,
        output delta_x, output delta_y, output cursor_x, output cursor_y, input ready
    );
    modport sink (
        input valid, input button_left, input button_right, input button_middle,
        input delta_x, input delta_y, input cursor_x, input cursor_y, output ready
    );
endinterface

// ===== hdl/ps2_mouse_packet_tracker_unit.sv =====
// channel   dir  payload                                        beat taken when
// i_in      in   ctrl_status[7:0], rx_byte[7:0]                 valid && ready
// o_out     out  buttons x3, delta_x[8:0], delta_y[9:0],        valid && ready
//                cursor_x[31:0], cursor_y[31:0]
// apb       in   start_x @0x0, start_y @0x4, 32-bit data        psel && penable && pwrite
//
// One input byte per cycle while the packet queue has room; a packet result is written into
// the packet queue when its third byte is accepted and then moves to the output register.
// Reset is synchronous; no clearing pass is needed.
// A stalled output fills the packet queue (QUEUE_DEPTH packets) before i_in.ready falls.
module ps2_mouse_packet_tracker_unit #(
    parameter int QUEUE_DEPTH = ps2mt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ps2mt_in_if.sink                       i_in,
    ps2mt_out_if.source                    o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ps2mt_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ps2mt_pkg::*;

    logic signed [31:0] r_start_x;
    logic signed [31:0] r_start_y;
    logic               w_wr;
    t_cfg               w_cfg;
    t_push              w_push;
    t_pkt               w_pkt;
    logic               w_full, w_empty, w_pop;

    // decode register writes on bit 2 of the address
    assign pready     = 1'b1;
    assign w_wr       = psel && penable && pwrite && pready;
    assign w_cfg.wr_x = w_wr && (paddr[2] == ADDR_START_X[2]);
    assign w_cfg.wr_y = w_wr && (paddr[2] == ADDR_START_Y[2]);
    assign w_cfg.data = $signed(pwdata);
    assign prdata     = (paddr[2] == ADDR_START_Y[2]) ? r_start_y : r_start_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= START_X_RST;
            r_start_y <= START_Y_RST;
        end else begin
            if (w_cfg.wr_x) r_start_x <= w_cfg.data;
            if (w_cfg.wr_y) r_start_y <= w_cfg.data;
        end
    end

    ps2mt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    ps2mt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_pkt   (w_pkt)
    );

    ps2mt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_empty (w_empty),
        .i_pkt   (w_pkt),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== hdl/ps2mt_front.sv =====
module ps2mt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ps2mt_in_if.sink        i_in,
    input  logic            i_full,
    output ps2mt_pkg::t_push o_push
);
    import ps2mt_pkg::*;

    t_idx       r_idx, n_idx;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic       w_take;

    // stall only when the queue has no room
    assign i_in.ready = !i_full;
    assign w_take = i_in.valid && i_in.ready
                 && i_in.ctrl_status[STAT_OBF] && i_in.ctrl_status[STAT_AUX];

    // next byte position
    always_comb begin
        n_idx = r_idx;
        if (w_take) begin
            case (r_idx)
                IDX_SECOND: n_idx = IDX_THIRD;
                IDX_THIRD:  n_idx = IDX_FIRST;
                default:    n_idx = i_in.rx_byte[FB_SYNC] ? IDX_SECOND : IDX_FIRST;
            endcase
        end
    end

    // capture bytes and push a finished packet
    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        o_push.valid = 1'b0;
        o_push.pkt.first_byte  = r_first;
        o_push.pkt.second_byte = r_second;
        o_push.pkt.third_byte  = i_in.rx_byte;
        if (w_take) begin
            case (r_idx)
                IDX_SECOND: n_second = i_in.rx_byte;
                IDX_THIRD:  o_push.valid = 1'b1;
                default: begin
                    if (i_in.rx_byte[FB_SYNC]) n_first = i_in.rx_byte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= IDX_FIRST;
            r_first  <= 8'd0;
            r_second <= 8'd0;
        end else begin
            r_idx    <= n_idx;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

// ===== hdl/ps2mt_fifo.sv =====
module ps2mt_fifo #(
    parameter int DEPTH = ps2mt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ps2mt_pkg::t_push i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output ps2mt_pkg::t_pkt  o_pkt
);
    import ps2mt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_pkt   = r_mem[r_rd];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // advance pointers with wrap
    always_comb begin
        n_wr    = w_wr ? ((r_wr == LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = w_rd ? ((r_rd == LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count;
        if (w_wr && !w_rd) n_count = r_count + 1'b1;
        else if (!w_wr && w_rd) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr] <= i_push.pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_full))
        else $error("packet pushed into full queue");

endmodule

// ===== hdl/ps2mt_back.sv =====
module ps2mt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ps2mt_pkg::t_cfg i_cfg,
    input  logic            i_empty,
    input  ps2mt_pkg::t_pkt i_pkt,
    output logic            o_pop,
    ps2mt_out_if.source     o_out
);
    import ps2mt_pkg::*;

    logic signed [31:0] r_pos_x, n_pos_x;
    logic signed [31:0] r_pos_y, n_pos_y;
    logic               r_valid;
    logic               r_left, r_right, r_middle;
    logic signed [8:0]  r_dx, n_dx;
    logic signed [9:0]  r_dy, n_dy;
    logic [8:0]         w_dy9;
    logic [32:0]        w_sum_x, w_sum_y;

    // take a packet whenever the output beat is free or leaving
    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    // sign-extend movements, negate Y
    always_comb begin
        n_dx  = {i_pkt.first_byte[FB_XSIGN], i_pkt.second_byte};
        w_dy9 = {i_pkt.first_byte[FB_YSIGN], i_pkt.third_byte};
        n_dy  = -$signed({w_dy9[8], w_dy9});
    end

    // saturating cursor update
    always_comb begin
        w_sum_x = {r_pos_x[31], r_pos_x} + {{24{n_dx[8]}}, n_dx};
        w_sum_y = {r_pos_y[31], r_pos_y} + {{23{n_dy[9]}}, n_dy};
        if (w_sum_x[32] != w_sum_x[31]) n_pos_x = w_sum_x[32] ? POS_MIN : POS_MAX;
        else n_pos_x = $signed(w_sum_x[31:0]);
        if (w_sum_y[32] != w_sum_y[31]) n_pos_y = w_sum_y[32] ? POS_MIN : POS_MAX;
        else n_pos_y = $signed(w_sum_y[31:0]);
    end

    // position registers: loaded by configuration, moved by packets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= START_X_RST;
            r_pos_y <= START_Y_RST;
        end else begin
            if (i_cfg.wr_x) r_pos_x <= i_cfg.data;
            else if (o_pop) r_pos_x <= n_pos_x;
            if (i_cfg.wr_y) r_pos_y <= i_cfg.data;
            else if (o_pop) r_pos_y <= n_pos_y;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_left   <= i_pkt.first_byte[FB_LEFT];
            r_right  <= i_pkt.first_byte[FB_RIGHT];
            r_middle <= i_pkt.first_byte[FB_MIDDLE];
            r_dx     <= n_dx;
            r_dy     <= n_dy;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.button_left   = r_left;
    assign o_out.button_right  = r_right;
    assign o_out.button_middle = r_middle;
    assign o_out.delta_x       = r_dx;
    assign o_out.delta_y       = r_dy;
    assign o_out.cursor_x      = r_pos_x;
    assign o_out.cursor_y      = r_pos_y;

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped packet produced no beat");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_out.ready && i_empty) |=> !r_valid)
        else $error("beat repeated after delivery");

endmodule
